// ----- rtl/vk7_pkg.sv -----
`timescale 1ns / 1ps
package vk7_pkg;

  localparam int NUM_STATES = 64;
  localparam int STATE_W    = 6;
  localparam int METRIC_W   = 16;
  localparam logic [METRIC_W-1:0] METRIC_INIT = 16'h7FFF;

  localparam int FRAME_W = 16;
  localparam int DATA_W  = FRAME_W + 3;  // data bits = 8 * frame bytes
  localparam int BYTES_W = FRAME_W + 1;  // coded bytes per frame
  localparam int CFG_W   = FRAME_W;

  localparam int DEF_WINDOW = 128;
  localparam int DEF_FLUSH  = 128;

  typedef enum logic [0:0] {
    REG_RATE_MODE   = 1'b0,
    REG_FRAME_BYTES = 1'b1
  } reg_index_t;

  // controls from the sequencer to the ACS unit
  typedef struct packed {
    logic init;
    logic stage;
    logic v0;
    logic r0;
    logic v1;
    logic r1;
    logic scan_load;
    logic scan_step;
  } acs_ctrl_t;

  // expected {g0, g1} on the branch into sp from its even predecessor
  function automatic logic [1:0] branch_code(input logic [STATE_W-1:0] sp);
    logic                b;
    logic [STATE_W-1:0]  p0;
    b  = sp[STATE_W-1];
    p0 = {sp[STATE_W-2:0], 1'b0};
    return {b ^ p0[4] ^ p0[3] ^ p0[1] ^ p0[0], b ^ p0[5] ^ p0[4] ^ p0[3] ^ p0[0]};
  endfunction

endpackage

// ----- rtl/vk7_acs.sv -----
`timescale 1ns / 1ps
module vk7_acs (
  input  logic                            clk,
  input  logic                            rst,
  input  vk7_pkg::acs_ctrl_t              ctrl,
  output logic [vk7_pkg::NUM_STATES-1:0]  survivors,
  output logic [vk7_pkg::STATE_W-1:0]     best_state
);
  import vk7_pkg::*;

  logic [METRIC_W-1:0] metrics      [NUM_STATES];
  logic [METRIC_W-1:0] metrics_next [NUM_STATES];
  logic [METRIC_W-1:0] cand_val     [NUM_STATES];
  logic [STATE_W-1:0]  cand_idx     [NUM_STATES];
  logic [1:0]          active;

  assign active = 2'(ctrl.v0) + 2'(ctrl.v1);

  for (genvar sp = 0; sp < NUM_STATES; sp++) begin : g_acs
    localparam int P0 = (sp % (NUM_STATES / 2)) * 2;
    logic [1:0]          g;
    logic [1:0]          bm0;
    logic [1:0]          bm1;
    logic [METRIC_W-1:0] c0;
    logic [METRIC_W-1:0] c1;
    assign g   = branch_code(STATE_W'(sp));
    assign bm0 = 2'(ctrl.v0 & (ctrl.r0 ^ g[1])) + 2'(ctrl.v1 & (ctrl.r1 ^ g[0]));
    assign bm1 = active - bm0;
    assign c0  = metrics[P0] + METRIC_W'(bm0);
    assign c1  = metrics[P0 + 1] + METRIC_W'(bm1);
    assign survivors[sp]    = (c1 < c0);
    assign metrics_next[sp] = (c1 < c0) ? c1 : c0;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        metrics[s] <= (s == 0) ? '0 : METRIC_INIT;
      end
    end else if (ctrl.stage) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        metrics[s] <= metrics_next[s];
      end
    end
  end

  // min search: halve the candidate list in place, one tree level a cycle;
  // ties keep the lower index
  always_ff @(posedge clk) begin
    if (ctrl.scan_load) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        cand_val[s] <= metrics[s];
        cand_idx[s] <= STATE_W'(s);
      end
    end else if (ctrl.scan_step) begin
      for (int s = 0; s < NUM_STATES / 2; s++) begin
        if (cand_val[2*s+1] < cand_val[2*s]) begin
          cand_val[s] <= cand_val[2*s+1];
          cand_idx[s] <= cand_idx[2*s+1];
        end else begin
          cand_val[s] <= cand_val[2*s];
          cand_idx[s] <= cand_idx[2*s];
        end
      end
    end
  end

  assign best_state = cand_idx[0];

endmodule

// ----- rtl/viterbi_k7_sliding_window_decoder.sv -----
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// cfg      in   cfg_write            cfg_index, cfg_data
// in       in   in_valid / in_stall  coded_byte
// out      out  out_valid/out_stall  decoded_byte, last_of_run, frame_end
//
// One coded byte: an accept, then one ACS stage per trellis step (4 at rate 1/2,
// 5 or 6 at rate 2/3), then a wrap-up. A window adds a min search, a priming read
// and one survivor memory read per traceback step (WINDOW_LENGTH + FLUSH_LENGTH
// steps) and the emission of its decoded bytes. A frame's last byte also runs the
// padding and flush stages. Sync reset, no clearing pass.
// Output stalls hold the sequencer only when a decoded byte has nowhere to go.
module viterbi_k7_sliding_window_decoder #(
  parameter int WINDOW_LENGTH = vk7_pkg::DEF_WINDOW,
  parameter int FLUSH_LENGTH  = vk7_pkg::DEF_FLUSH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [0:0]                cfg_index,
  input  logic [vk7_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                coded_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                decoded_byte,
  output logic                      last_of_run,
  output logic                      frame_end
);
  import vk7_pkg::*;

  localparam int RING_DEPTH   = WINDOW_LENGTH + FLUSH_LENGTH;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int PHASE_W      = $clog2(WINDOW_LENGTH);
  localparam int CNT_W        = $clog2((1 << DATA_W) + RING_DEPTH + 1);
  localparam int TRACE_W      = $clog2(RING_DEPTH);
  localparam int WIN_BYTES    = WINDOW_LENGTH / 8;
  localparam int EMIT_W       = $clog2(WIN_BYTES + 1);
  localparam int TAIL_PHASE0  = (WINDOW_LENGTH - (FLUSH_LENGTH % WINDOW_LENGTH)) % WINDOW_LENGTH;
  localparam int TB_OFFSET    = RING_DEPTH - 1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DATA   = 8'b0000_0010,
    ST_TAIL   = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_PRIME  = 8'b0001_0000,
    ST_TRACE  = 8'b0010_0000,
    ST_EMIT   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  logic                rate_mode;
  logic [FRAME_W-1:0]  frame_bytes;

  logic [CNT_W-1:0]    stage_count;
  logic [PHASE_W-1:0]  window_phase;
  logic [PHASE_W-1:0]  tail_phase;     // (stage_count - FLUSH_LENGTH) mod WINDOW_LENGTH
  logic [RING_AW-1:0]  wr_idx;
  logic                carry_v;
  logic                carry_bit;
  logic [BYTES_W-1:0]  bytes_taken;
  logic [8:0]          word;
  logic [3:0]          avail;
  logic                frame_done;
  logic                ret_tail;
  logic [2:0]          scan_cnt;
  logic [RING_AW-1:0]  tb_idx;
  logic [TRACE_W-1:0]  trace_k;
  logic [STATE_W-1:0]  best;
  logic [WINDOW_LENGTH-1:0] win;
  logic [CNT_W-1:0]    emit_pos;
  logic [EMIT_W-1:0]   emit_cnt;
  logic                pend_v;
  logic [7:0]          pend_byte;
  logic                pend_fend;

  logic [NUM_STATES-1:0] ring [RING_DEPTH];
  logic [NUM_STATES-1:0] rd_data;
  logic [NUM_STATES-1:0] survivors;
  logic [STATE_W-1:0]    best_state;
  acs_ctrl_t             acs_ctrl;

  // derived frame sizes
  logic [CNT_W-1:0]    data_ext;
  logic [17:0]         three_fb;
  logic [BYTES_W-1:0]  coded_bytes;
  logic [BYTES_W-1:0]  bytes_next;

  assign data_ext = CNT_W'({frame_bytes, 3'b000});
  assign three_fb = 18'(frame_bytes) + 18'({frame_bytes, 1'b0});
  assign coded_bytes = rate_mode ? BYTES_W'((three_fb + 18'd1) >> 1)
                                 : BYTES_W'({frame_bytes, 1'b0});
  assign bytes_next = bytes_taken + BYTES_W'(1);

  // stage decisions
  logic                need2;
  logic                data_go;
  logic                tail_go;
  logic                stage_fire;
  logic                tb_hit;
  logic                r0;
  logic                r1;
  logic [CNT_W-1:0]    tb_start;
  logic                accept;
  logic                out_free;
  logic                emit_done;
  logic                push;
  logic                out_load;
  logic                rd_en;
  logic [RING_AW-1:0]  wr_prev;
  logic [RING_AW-1:0]  tb_prev;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign need2   = !rate_mode || !stage_count[0];
  assign data_go = (stage_count < data_ext) && (avail >= (need2 ? 4'd2 : 4'd1));
  assign tail_go = (stage_count < CNT_W'(FLUSH_LENGTH)) ||
                   (data_ext > stage_count - CNT_W'(FLUSH_LENGTH) - CNT_W'(tail_phase));
  assign stage_fire = ((state == ST_DATA) && data_go) || ((state == ST_TAIL) && tail_go);
  assign r0 = word[4'(avail - 4'd1)];
  assign r1 = word[4'(avail - 4'd2)];

  assign tb_start = stage_count - CNT_W'(TB_OFFSET);
  assign tb_hit   = (window_phase == PHASE_W'(WINDOW_LENGTH - 1)) &&
                    (stage_count >= CNT_W'(TB_OFFSET)) && (tb_start < data_ext);

  assign emit_done = (emit_cnt == EMIT_W'(WIN_BYTES)) || (emit_pos >= data_ext);
  assign push      = (state == ST_EMIT) && !emit_done && (!pend_v || out_free);
  assign out_load  = pend_v && out_free &&
                     (((state == ST_EMIT) && !emit_done) || (state == ST_FINISH));

  assign wr_prev = (wr_idx == '0) ? RING_AW'(RING_DEPTH - 1) : wr_idx - RING_AW'(1);
  assign tb_prev = (tb_idx == '0) ? RING_AW'(RING_DEPTH - 1) : tb_idx - RING_AW'(1);
  assign rd_en   = (state == ST_PRIME) || (state == ST_TRACE);

  always_comb begin
    acs_ctrl           = '0;
    acs_ctrl.init      = (state == ST_TAIL) && !tail_go;
    acs_ctrl.stage     = stage_fire;
    acs_ctrl.v0        = (state == ST_DATA);
    acs_ctrl.r0        = r0;
    acs_ctrl.v1        = (state == ST_DATA) && need2;
    acs_ctrl.r1        = r1;
    acs_ctrl.scan_load = (state == ST_SCAN) && (scan_cnt == 3'd0);
    acs_ctrl.scan_step = (state == ST_SCAN) && (scan_cnt != 3'd0);
  end

  vk7_acs u_acs (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (acs_ctrl),
    .survivors  (survivors),
    .best_state (best_state)
  );

  // survivor ring
  always_ff @(posedge clk) begin
    if (stage_fire) begin
      ring[wr_idx] <= survivors;
    end
    if (rd_en) begin
      rd_data <= ring[tb_idx];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_mode   <= 1'b0;
      frame_bytes <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_RATE_MODE:   rate_mode   <= cfg_data[0];
        REG_FRAME_BYTES: frame_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stage_count  <= '0;
      window_phase <= '0;
      tail_phase   <= PHASE_W'(TAIL_PHASE0);
      wr_idx       <= '0;
      carry_v      <= 1'b0;
      carry_bit    <= 1'b0;
      bytes_taken  <= '0;
      frame_done   <= 1'b0;
      ret_tail     <= 1'b0;
      scan_cnt     <= '0;
      trace_k      <= '0;
      emit_cnt     <= '0;
      pend_v       <= 1'b0;
    end else begin
      if (stage_fire) begin
        wr_idx       <= (wr_idx == RING_AW'(RING_DEPTH - 1)) ? '0 : wr_idx + RING_AW'(1);
        stage_count  <= stage_count + CNT_W'(1);
        window_phase <= (window_phase == PHASE_W'(WINDOW_LENGTH - 1)) ? '0
                        : window_phase + PHASE_W'(1);
        tail_phase   <= (tail_phase == PHASE_W'(WINDOW_LENGTH - 1)) ? '0
                        : tail_phase + PHASE_W'(1);
        if (state == ST_DATA) begin
          avail <= avail - (need2 ? 4'd2 : 4'd1);
        end
        if (tb_hit) begin
          state    <= ST_SCAN;
          scan_cnt <= '0;
          emit_pos <= tb_start;
          ret_tail <= (state == ST_TAIL);
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            word        <= {carry_v & carry_bit, coded_byte};
            avail       <= carry_v ? 4'd9 : 4'd8;
            bytes_taken <= bytes_next;
            frame_done  <= (bytes_next >= coded_bytes);
            state       <= ST_DATA;
          end
        end
        ST_DATA: begin
          if (!data_go) begin
            // an odd leftover bit carries into the next transaction
            carry_v   <= (avail <= 4'd8) && avail[0];
            carry_bit <= word[0];
            state     <= frame_done ? ST_TAIL : ST_FINISH;
          end
        end
        ST_TAIL: begin
          if (!tail_go) begin
            stage_count  <= '0;
            window_phase <= '0;
            tail_phase   <= PHASE_W'(TAIL_PHASE0);
            wr_idx       <= '0;
            carry_v      <= 1'b0;
            carry_bit    <= 1'b0;
            bytes_taken  <= '0;
            state        <= ST_FINISH;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 3'd1;
          if (scan_cnt == 3'd0) begin
            tb_idx <= wr_prev;
          end
          if (scan_cnt == 3'(STATE_W)) begin
            state <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          best    <= best_state;
          tb_idx  <= tb_prev;
          trace_k <= '0;
          state   <= ST_TRACE;
        end
        ST_TRACE: begin
          best    <= {best[STATE_W-2:0], rd_data[best]};
          tb_idx  <= tb_prev;
          trace_k <= trace_k + TRACE_W'(1);
          if (trace_k >= TRACE_W'(FLUSH_LENGTH)) begin
            win <= {best[STATE_W-1], win[WINDOW_LENGTH-1:1]};
          end
          if (trace_k == TRACE_W'(RING_DEPTH - 1)) begin
            emit_cnt <= '0;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_done) begin
            state <= ret_tail ? ST_TAIL : ST_DATA;
          end else if (push) begin
            pend_v    <= 1'b1;
            pend_byte <= win[WINDOW_LENGTH-1 -: 8];
            pend_fend <= (CNT_W'(emit_pos + CNT_W'(8)) >= data_ext);
            win       <= win << 8;
            emit_pos  <= emit_pos + CNT_W'(8);
            emit_cnt  <= emit_cnt + EMIT_W'(1);
          end
        end
        ST_FINISH: begin
          if (!pend_v) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_v <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      decoded_byte <= pend_byte;
      frame_end    <= pend_fend;
      last_of_run  <= (state == ST_FINISH);
    end
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_v)
    else $error("pending result left when idle");

  a_phase_at_start: assert property (@(posedge clk) disable iff (rst)
    (stage_count == '0) |-> (window_phase == '0))
    else $error("window phase out of step with stage count");

  a_trace_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRACE && trace_k == TRACE_W'(RING_DEPTH - 1)) |=> (state == ST_EMIT))
    else $error("traceback did not end in emit");

  a_ring_write_ctx: assert property (@(posedge clk) disable iff (rst)
    stage_fire |-> (state == ST_DATA || state == ST_TAIL))
    else $error("survivor write outside a stage");
`endif

endmodule
